// ===== design/glr_pkg.sv =====
// Shared constants, codes and control types for the gradient line rasteriser.
package glr_pkg;

  localparam int COORD_BITS_DEF = 15;
  localparam int SCREEN_MAX_DEF = 4096;

  localparam int SCR_W   = 13;
  localparam int ADDR_W  = 24;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int LANES   = 3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SCR_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

  localparam logic [SCR_W-1:0] WIDTH_RESET  = 13'd1024;
  localparam logic [SCR_W-1:0] HEIGHT_RESET = 13'd768;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SQR     = 8'b0000_0010,
    S_ROOT_GO = 8'b0000_0100,
    S_ROOT    = 8'b0000_1000,
    S_DIV_GO  = 8'b0001_0000,
    S_DIV     = 8'b0010_0000,
    S_ADDR    = 8'b0100_0000,
    S_OUT     = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic take;
    logic sqr;
    logic root_go;
    logic div_go;
    logic addr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_mode;
    logic line_done;
    logic root_done;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== design/glr_if.sv =====
// Valid/ready channel interfaces for input words and pixel result words.
interface glr_in_if import glr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_from;
  logic signed [COORD_BITS-1:0] y_from;
  logic signed [COORD_BITS-1:0] x_to;
  logic signed [COORD_BITS-1:0] y_to;
  logic [COLOR_W-1:0]           color_from;
  logic [COLOR_W-1:0]           color_to;

  modport source (output valid, mode, x_from, y_from, x_to, y_to, color_from, color_to,
                  input ready);
  modport sink   (input valid, mode, x_from, y_from, x_to, y_to, color_from, color_to,
                  output ready);
endinterface

interface glr_out_if import glr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [ADDR_W-1:0]            pixel_address;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         write_enable;
  logic                         last;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color,
                  write_enable, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color,
                  write_enable, last, output ready);
endinterface

// ===== design/glr_isqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
module glr_isqrt import glr_pkg::*; #(
  parameter int RT_W = COORD_BITS_DEF + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2*RT_W-1:0] rad,
  output logic              done,
  output logic [RT_W-1:0]   root
);
  localparam int RAD_W = 2 * RT_W;
  localparam int REM_W = RT_W + 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [RT_W-1:0]  root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             done_r;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  logic             fits;

  // Bring in two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
      cnt_r  <= CNT_W'(RT_W - 1);
    end else if (run_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_r  <= REM_W'(rem_sh - trial);
        root_r <= {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= REM_W'(rem_sh);
        root_r <= {root_r[RT_W-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== design/glr_div.sv =====
// Restoring divider, one quotient bit per cycle, three colour lanes side by side.
module glr_div import glr_pkg::*; #(
  parameter int NUM_W = 24,
  parameter int DEN_W = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [LANES-1:0][NUM_W-1:0] num,
  input  logic [DEN_W-1:0]            den,
  output logic                        done,
  output logic [LANES-1:0][NUM_W-1:0] quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [LANES-1:0][NUM_W-1:0] quo_r;
  logic [LANES-1:0][DEN_W-1:0] rem_r;
  logic [DEN_W-1:0]            den_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        run_r;
  logic                        done_r;

  logic [LANES-1:0][DEN_W:0]   rem_sh;
  logic [LANES-1:0]            fits;

  // Shift in the next numerator bit and subtract where the divisor fits
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rem_sh[k] = {rem_r[k], quo_r[k][NUM_W-1]};
      fits[k]   = rem_sh[k] >= {1'b0, den_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == '0) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
      cnt_r <= CNT_W'(NUM_W - 1);
    end else if (run_r) begin
      for (int k = 0; k < LANES; k++) begin
        if (fits[k]) begin
          rem_r[k] <= DEN_W'(rem_sh[k] - {1'b0, den_r});
        end else begin
          rem_r[k] <= DEN_W'(rem_sh[k]);
        end
        quo_r[k] <= {quo_r[k][NUM_W-2:0], fits[k]};
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== design/glr_ctrl.sv =====
// Sequencer for line loading, pixel stepping and result hand-off.
module glr_ctrl import glr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Issue commands and pick the next state
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.in_mode == MODE_LOAD) begin
            state_nxt = S_SQR;
          end else if (sts.line_done) begin
            state_nxt = S_ADDR;
          end else begin
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_go = 1'b1;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = S_ADDR;
        end
      end
      S_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.addr  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/glr_dp.sv =====
// Datapath: line state, Bresenham step, colour blend, clipping and output register.
module glr_dp import glr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SCREEN_MAX = SCREEN_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         in_mode,
  input  logic signed [COORD_BITS-1:0] in_x_from,
  input  logic signed [COORD_BITS-1:0] in_y_from,
  input  logic signed [COORD_BITS-1:0] in_x_to,
  input  logic signed [COORD_BITS-1:0] in_y_to,
  input  logic [COLOR_W-1:0]           in_color_from,
  input  logic [COLOR_W-1:0]           in_color_to,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_pixel_x,
  output logic signed [COORD_BITS-1:0] out_pixel_y,
  output logic [ADDR_W-1:0]            out_pixel_address,
  output logic [COLOR_W-1:0]           out_pixel_color,
  output logic                         out_write_enable,
  output logic                         out_last
);
  localparam int CB     = COORD_BITS;
  localparam int STEP_W = CB + 1;
  localparam int NUM_W  = CH_W + STEP_W;
  localparam int SQ_W   = 2 * CB + 1;
  localparam int CMP_W  = (CB > SCR_W) ? CB : SCR_W;
  localparam int APS_W  = SCR_W + CB;

  // Screen registers
  logic [SCR_W-1:0] scr_w_r, scr_h_r;
  logic [SCR_W-1:0] cfg_clamped;

  // Line state
  logic signed [CB-1:0]  cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic [CB-1:0]         dlx_r, dly_r;
  logic                  sxn_r, syn_r;
  logic signed [CB+1:0]  err_r;
  logic [STEP_W-1:0]     len_r, idx_r;
  logic [COLOR_W-1:0]    col_s_r, col_e_r;
  logic                  done_r;

  // Per-pixel working registers
  logic signed [CB-1:0]        px_r, py_r;
  logic                        blank_r, last_r, use_end_r;
  logic [LANES-1:0][NUM_W-1:0] mag_r;
  logic [LANES-1:0]            neg_r;
  logic [SQ_W-1:0]             sq_r;
  logic                        in_scr_r;
  logic [APS_W-2:0]            aprod_r;
  logic [COLOR_W-1:0]          color_r;

  // Output register
  logic                 out_valid_r;
  logic signed [CB-1:0] opx_r, opy_r;
  logic [ADDR_W-1:0]    oaddr_r;
  logic [COLOR_W-1:0]   ocol_r;
  logic                 owe_r, olast_r;

  // Combinational helpers
  logic signed [CB:0]   dx_c, dy_c;
  logic [CB-1:0]        adx_c, ady_c;
  logic signed [CB+2:0] e2_c;
  logic                 stx_c, sty_c;
  logic signed [CB+1:0] err_c;
  logic signed [CB-1:0] nx_c, ny_c;
  logic [LANES-1:0][CH_W:0]    dif_c;
  logic [LANES-1:0][CH_W-1:0]  magd_c;
  logic [LANES-1:0][NUM_W-1:0] mag_c;
  logic [STEP_W-1:0]    den_c;
  logic [STEP_W-1:0]    root_c;
  logic                 root_done;
  logic                 div_done;
  logic [LANES-1:0][NUM_W-1:0] quo_c;
  logic [COLOR_W-1:0]   blend_c;
  logic [CH_W-1:0]      q8_c;
  logic                 in_scr_c;
  logic [APS_W-1:0]     asum_c;

  // Saturate configuration writes to the largest screen
  assign cfg_clamped = (cfg_data > SCR_W'(SCREEN_MAX)) ? SCR_W'(SCREEN_MAX) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= WIDTH_RESET;
      scr_h_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  scr_w_r <= cfg_clamped;
        CFG_HEIGHT: scr_h_r <= cfg_clamped;
        default: begin
        end
      endcase
    end
  end

  // Endpoint deltas and the Bresenham step
  always_comb begin
    dx_c  = $signed({in_x_to[CB-1], in_x_to}) - $signed({in_x_from[CB-1], in_x_from});
    dy_c  = $signed({in_y_to[CB-1], in_y_to}) - $signed({in_y_from[CB-1], in_y_from});
    adx_c = dx_c[CB] ? CB'(-dx_c) : CB'(dx_c);
    ady_c = dy_c[CB] ? CB'(-dy_c) : CB'(dy_c);
    e2_c  = $signed({err_r, 1'b0});
    stx_c = e2_c > -$signed({3'b000, dly_r});
    sty_c = e2_c < $signed({3'b000, dlx_r});
    err_c = err_r;
    nx_c  = cur_x_r;
    ny_c  = cur_y_r;
    if (stx_c) begin
      err_c = err_c - $signed({2'b00, dly_r});
      nx_c  = cur_x_r + (sxn_r ? {CB{1'b1}} : CB'(1));
    end
    if (sty_c) begin
      err_c = err_c + $signed({2'b00, dlx_r});
      ny_c  = cur_y_r + (syn_r ? {CB{1'b1}} : CB'(1));
    end
  end

  // Colour differences scaled by the step index
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      dif_c[k]  = {1'b0, col_e_r[k*CH_W +: CH_W]} - {1'b0, col_s_r[k*CH_W +: CH_W]};
      magd_c[k] = dif_c[k][CH_W] ? CH_W'(-dif_c[k]) : dif_c[k][CH_W-1:0];
      mag_c[k]  = NUM_W'(magd_c[k]) * NUM_W'(idx_r);
    end
  end

  // Capture a word and update the line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b1;
    end else if (cmd.take) begin
      if (in_mode == MODE_LOAD) begin
        done_r <= (in_x_from == in_x_to) && (in_y_from == in_y_to);
      end else if (!done_r) begin
        done_r <= (nx_c == end_x_r) && (ny_c == end_y_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (in_mode == MODE_LOAD) begin
        cur_x_r   <= in_x_from;
        cur_y_r   <= in_y_from;
        end_x_r   <= in_x_to;
        end_y_r   <= in_y_to;
        col_s_r   <= in_color_from;
        col_e_r   <= in_color_to;
        dlx_r     <= adx_c;
        dly_r     <= ady_c;
        sxn_r     <= !(in_x_from < in_x_to);
        syn_r     <= !(in_y_from < in_y_to);
        err_r     <= $signed({2'b00, adx_c}) - $signed({2'b00, ady_c});
        idx_r     <= STEP_W'(1);
        px_r      <= in_x_to;
        py_r      <= in_y_to;
        last_r    <= (in_x_from == in_x_to) && (in_y_from == in_y_to);
        blank_r   <= 1'b0;
        use_end_r <= 1'b1;
      end else if (done_r) begin
        blank_r <= 1'b1;
        last_r  <= 1'b1;
      end else begin
        px_r      <= cur_x_r;
        py_r      <= cur_y_r;
        cur_x_r   <= nx_c;
        cur_y_r   <= ny_c;
        err_r     <= err_c;
        idx_r     <= idx_r + 1'b1;
        last_r    <= (nx_c == end_x_r) && (ny_c == end_y_r);
        blank_r   <= 1'b0;
        use_end_r <= 1'b0;
        mag_r     <= mag_c;
        for (int k = 0; k < LANES; k++) begin
          neg_r[k] <= dif_c[k][CH_W];
        end
      end
    end
    if (cmd.sqr) begin
      sq_r <= SQ_W'(SQ_W'(dlx_r) * SQ_W'(dlx_r)) + SQ_W'(SQ_W'(dly_r) * SQ_W'(dly_r));
    end
    if (root_done) begin
      len_r <= root_c;
    end
  end

  // Line length from the sum of squares
  glr_isqrt #(
    .RT_W (STEP_W)
  ) u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_go),
    .rad   ((2*STEP_W)'(sq_r)),
    .done  (root_done),
    .root  (root_c)
  );

  assign den_c = (len_r == '0) ? STEP_W'(1) : len_r;

  glr_div #(
    .NUM_W (NUM_W),
    .DEN_W (STEP_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (mag_r),
    .den   (den_c),
    .done  (div_done),
    .quo   (quo_c)
  );

  // Blend each channel from its start value and signed quotient
  always_comb begin
    blend_c = '0;
    q8_c    = '0;
    for (int k = 0; k < LANES; k++) begin
      q8_c = quo_c[k][CH_W-1:0];
      blend_c[k*CH_W +: CH_W] = col_s_r[k*CH_W +: CH_W] + (neg_r[k] ? -q8_c : q8_c);
    end
  end

  // Clip against the screen
  assign in_scr_c = !px_r[CB-1] && !py_r[CB-1] &&
                    (CMP_W'(px_r[CB-2:0]) < CMP_W'(scr_w_r)) &&
                    (CMP_W'(py_r[CB-2:0]) < CMP_W'(scr_h_r));

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      in_scr_r <= in_scr_c;
      aprod_r  <= (APS_W-1)'((APS_W-1)'(scr_w_r) * (APS_W-1)'(py_r[CB-2:0]));
      color_r  <= use_end_r ? col_e_r : blend_c;
    end
  end

  assign asum_c = {1'b0, aprod_r} + APS_W'(px_r[CB-2:0]);

  // Load the output register; drop valid once the word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (blank_r) begin
        opx_r   <= '0;
        opy_r   <= '0;
        oaddr_r <= '0;
        ocol_r  <= '0;
        owe_r   <= 1'b0;
        olast_r <= 1'b1;
      end else begin
        opx_r   <= px_r;
        opy_r   <= py_r;
        oaddr_r <= in_scr_r ? ADDR_W'(asum_c) : '0;
        ocol_r  <= color_r;
        owe_r   <= in_scr_r;
        olast_r <= last_r;
      end
    end
  end

  assign sts.in_mode   = in_mode;
  assign sts.line_done = done_r;
  assign sts.root_done = root_done;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid         = out_valid_r;
  assign out_pixel_x       = opx_r;
  assign out_pixel_y       = opy_r;
  assign out_pixel_address = oaddr_r;
  assign out_pixel_color   = ocol_r;
  assign out_write_enable  = owe_r;
  assign out_last          = olast_r;

endmodule

// ===== design/gradient_line_rasterizer.sv =====
// Top level: Bresenham line rasteriser with per-pixel colour gradient.
//
//   channel | direction | handshake      | word
//   in_ch   | in        | valid / ready  | mode, endpoints, two colours
//   out_ch  | out       | valid / ready  | pixel x/y, address, colour, write enable, last
//   cfg_*   | in        | cfg_we         | screen width / height
//
// A line load squares the deltas and takes the bit-serial square root over
// COORD_BITS+1 root bits for the line length; a pixel step runs the serial
// divider that works the three colour channels side by side, one quotient bit a cycle
// over CH_W+COORD_BITS+1 bits; a request with no line active goes straight to the
// address step. One word is in flight at a time; the next is taken once the result
// is in the output register. A stalled output holds the block in its hand-off state.
// Reset is synchronous and active low; screen size resets to 1024 x 768.
module gradient_line_rasterizer import glr_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int SCREEN_MAX = SCREEN_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  glr_in_if.sink                in_ch,
  glr_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  glr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  assign in_ch.ready = in_ready;

  glr_dp #(
    .COORD_BITS (COORD_BITS),
    .SCREEN_MAX (SCREEN_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_mode           (in_ch.mode),
    .in_x_from         (in_ch.x_from),
    .in_y_from         (in_ch.y_from),
    .in_x_to           (in_ch.x_to),
    .in_y_to           (in_ch.y_to),
    .in_color_from     (in_ch.color_from),
    .in_color_to       (in_ch.color_to),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_pixel_x       (out_ch.pixel_x),
    .out_pixel_y       (out_ch.pixel_y),
    .out_pixel_address (out_ch.pixel_address),
    .out_pixel_color   (out_ch.pixel_color),
    .out_write_enable  (out_ch.write_enable),
    .out_last          (out_ch.last)
  );

endmodule

// ===== test/glr_pixel_checker.sv =====
// Pixel checker: watches both channels, predicts each pixel word and compares.
`timescale 1ns / 100ps
module glr_pixel_checker import glr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  glr_in_if    in_ch,
  glr_out_if   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  typedef struct {
    logic signed [COORD_BITS_DEF-1:0] x;
    logic signed [COORD_BITS_DEF-1:0] y;
    logic [ADDR_W-1:0]                addr;
    logic [COLOR_W-1:0]               color;
    logic                             we;
    logic                             last;
  } pixel_t;

  pixel_t pixel_q[$];

  // screen size and walk state of the line being drawn
  int unsigned scr_w, scr_h;
  int          pos_x, pos_y, tgt_x, tgt_y, run_x, run_y, err;
  bit          back_x, back_y, walk_done;
  int unsigned len, step;
  logic [23:0] col_a, col_b;

  assign pending = pixel_q.size();

  function automatic int unsigned int_sqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n    -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return 32'(root);
  endfunction

  function automatic logic [7:0] shade(int sh);
    int a, b, d;
    a = int'((col_a >> sh) & 24'hFF);
    b = int'((col_b >> sh) & 24'hFF);
    d = (len != 0) ? int'(len) : 1;
    return 8'(a + (b - a) * int'(step) / d);
  endfunction

  function automatic pixel_t place(int x, int y, logic [23:0] c, bit fin);
    pixel_t p;
    bit on;
    on = x >= 0 && y >= 0 && x < int'(scr_w) && y < int'(scr_h);
    p.x     = x[COORD_BITS_DEF-1:0];
    p.y     = y[COORD_BITS_DEF-1:0];
    p.addr  = on ? 24'(scr_w * y + x) : '0;
    p.color = c;
    p.we    = on;
    p.last  = fin;
    return p;
  endfunction

  // work out the pixel word that an accepted input word yields
  task automatic predict_pixel();
    pixel_t p;
    int px, py, e2;
    logic [23:0] c;
    if (in_ch.mode == MODE_LOAD) begin
      pos_x = int'(in_ch.x_from); pos_y = int'(in_ch.y_from);
      tgt_x = int'(in_ch.x_to);   tgt_y = int'(in_ch.y_to);
      col_a = in_ch.color_from; col_b = in_ch.color_to;
      run_x = tgt_x > pos_x ? tgt_x - pos_x : pos_x - tgt_x;
      run_y = tgt_y > pos_y ? tgt_y - pos_y : pos_y - tgt_y;
      back_x = !(pos_x < tgt_x);
      back_y = !(pos_y < tgt_y);
      err = run_x - run_y;
      len = int_sqrt(longint'(run_x) * run_x + longint'(run_y) * run_y);
      step = 1;
      walk_done = pos_x == tgt_x && pos_y == tgt_y;
      p = place(tgt_x, tgt_y, col_b, walk_done);
    end else if (walk_done) begin
      p = '{x: '0, y: '0, addr: '0, color: '0, we: 1'b0, last: 1'b1};
    end else begin
      px = pos_x; py = pos_y;
      c = {shade(16), shade(8), shade(0)};
      e2 = err * 2;
      step = (step + 1) & 32'hFFFFF;
      if (e2 > -run_y) begin
        err -= run_y;
        pos_x += back_x ? -1 : 1;
      end
      if (e2 < run_x) begin
        err += run_x;
        pos_y += back_y ? -1 : 1;
      end
      walk_done = pos_x == tgt_x && pos_y == tgt_y;
      p = place(px, py, c, walk_done);
    end
    pixel_q.push_back(p);
  endtask

  always @(posedge clk) begin
    pixel_t exp_p;
    int unsigned v;
    if (!rst_n) begin
      scr_w = 32'(WIDTH_RESET); scr_h = 32'(HEIGHT_RESET);
      pos_x = 0; pos_y = 0; tgt_x = 0; tgt_y = 0; run_x = 0; run_y = 0; err = 0;
      back_x = 0; back_y = 0; walk_done = 1; len = 0; step = 0;
      col_a = '0; col_b = '0;
      errors = 0;
      pixel_q.delete();
    end else begin
      // compare the outgoing word with the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (pixel_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: pixel word with none expected", $realtime);
        end else begin
          exp_p = pixel_q.pop_front();
          if (out_ch.pixel_x !== exp_p.x || out_ch.pixel_y !== exp_p.y ||
              out_ch.pixel_address !== exp_p.addr || out_ch.pixel_color !== exp_p.color ||
              out_ch.write_enable !== exp_p.we || out_ch.last !== exp_p.last) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: exp x=%0d y=%0d a=%h c=%h we=%b l=%b",
                       $realtime, exp_p.x, exp_p.y, exp_p.addr, exp_p.color, exp_p.we,
                       exp_p.last);
              $display("      got x=%0d y=%0d a=%h c=%h we=%b l=%b",
                       out_ch.pixel_x, out_ch.pixel_y, out_ch.pixel_address,
                       out_ch.pixel_color, out_ch.write_enable, out_ch.last);
            end
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_pixel();
      // register writes saturate at the screen limit
      if (cfg_we) begin
        v = 32'(cfg_data);
        if (v > SCREEN_MAX_DEF) v = SCREEN_MAX_DEF;
        if (cfg_index == CFG_WIDTH) scr_w = v;
        else scr_h = v;
      end
    end
  end

endmodule

// ===== test/gradient_line_rasterizer_tb.sv =====
// Testbench top: drives lines and register writes, gives the verdict.
`timescale 1ns / 100ps
module gradient_line_rasterizer_tb;
  import glr_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_WORDS = 1150;

  logic clk, rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending, cycles, sent;
  int idle_pct, stall_pct;
  logic took;

  glr_in_if  #(.COORD_BITS(COORD_BITS_DEF)) in_ch ();
  glr_out_if #(.COORD_BITS(COORD_BITS_DEF)) out_ch ();

  gradient_line_rasterizer uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  glr_pixel_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // note each accepted input word for the driver
  always @(posedge clk) took <= in_ch.valid && in_ch.ready;

  // receiver stalls at random
  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  // give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("gradient_line_rasterizer_tb: done, errors");
      $finish;
    end
  end

  // hand one input word over; called on a falling edge, returns on one
  task automatic send_word(logic m, int xf, int yf, int xt, int yt,
                           logic [23:0] cf, logic [23:0] ct);
    if ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.x_from     <= xf[COORD_BITS_DEF-1:0];
    in_ch.y_from     <= yf[COORD_BITS_DEF-1:0];
    in_ch.x_to       <= xt[COORD_BITS_DEF-1:0];
    in_ch.y_to       <= yt[COORD_BITS_DEF-1:0];
    in_ch.color_from <= cf;
    in_ch.color_to   <= ct;
    do @(negedge clk); while (!took);
    sent++;
  endtask

  task automatic step_word();
    send_word(MODE_STEP, $urandom, $urandom, $urandom, $urandom,
              24'($urandom), 24'($urandom));
  endtask

  // load a line, then ask for a number of further pixels
  task automatic plot_segment(int xf, int yf, int xt, int yt,
                              logic [23:0] cf, logic [23:0] ct, int steps);
    send_word(MODE_LOAD, xf, yf, xt, yt, cf, ct);
    repeat (steps) step_word();
  endtask

  function automatic int walk_len(int xf, int yf, int xt, int yt);
    int ax, ay;
    ax = xt > xf ? xt - xf : xf - xt;
    ay = yt > yf ? yt - yf : yf - yt;
    return ax > ay ? ax : ay;
  endfunction

  // drop valid, let every pixel out, then write both registers
  task automatic set_screen(int w, int h);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_WIDTH; cfg_data <= w[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_HEIGHT; cfg_data <= h[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_line();
    int r, xf, yf, xt, yt, n;
    r = $urandom_range(99);
    if (r < 70) begin
      xf = $urandom_range(1200) - 60; yf = $urandom_range(900) - 60;
      xt = xf + $urandom_range(80) - 40; yt = yf + $urandom_range(80) - 40;
      n = walk_len(xf, yf, xt, yt) + $urandom_range(2);
    end else if (r < 78) begin
      xf = $urandom_range(1200) - 60; yf = $urandom_range(900) - 60;
      xt = xf + $urandom_range(600) - 300; yt = yf + $urandom_range(600) - 300;
      n = walk_len(xf, yf, xt, yt) + 1;
    end else if (r < 90) begin
      xf = $urandom_range(32767) - 16384; yf = $urandom_range(32767) - 16384;
      xt = $urandom_range(32767) - 16384; yt = $urandom_range(32767) - 16384;
      n = $urandom_range(6);
    end else begin
      // stray requests, or a line cut short
      if ($urandom_range(1)) begin
        repeat ($urandom_range(3) + 1) step_word();
        return;
      end
      xf = $urandom_range(200); yf = $urandom_range(200);
      xt = $urandom_range(200); yt = $urandom_range(200);
      n = $urandom_range(walk_len(xf, yf, xt, yt));
    end
    plot_segment(xf, yf, xt, yt, 24'($urandom), 24'($urandom), n);
  endtask

  initial begin
    int phase;
    rst_n = 0; cfg_we = 0; cfg_index = CFG_WIDTH; cfg_data = '0;
    in_ch.valid = 0; in_ch.mode = MODE_LOAD; in_ch.x_from = '0; in_ch.y_from = '0;
    in_ch.x_to = '0; in_ch.y_to = '0; in_ch.color_from = '0; in_ch.color_to = '0;
    out_ch.ready = 0;
    cycles = 0; sent = 0; idle_pct = 0; stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: no line yet, degenerate line, extremes, colour ends, clipping
    step_word();
    plot_segment(5, 5, 5, 5, 24'h123456, 24'hABCDEF, 2);
    plot_segment(-16384, -16384, 16383, 16383, 24'h000000, 24'hFFFFFF, 3);
    plot_segment(16383, -16384, -16384, 16383, 24'hFFFFFF, 24'h000000, 2);
    plot_segment(10, 3, 2, 7, 24'hFF00FF, 24'h00FF00, walk_len(10, 3, 2, 7) + 1);
    set_screen(0, 0);
    plot_segment(0, 0, 3, 1, 24'h0000FF, 24'hFF0000, 4);
    set_screen(8191, 4096);
    plot_segment(4093, 4094, 4097, 4095, 24'h808080, 24'h7F7F7F, 5);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  set_screen(1024, 768); end
        1: begin idle_pct = 57; stall_pct = 0;  set_screen(1, 1); end
        2: begin idle_pct = 0;  stall_pct = 57; set_screen(4096, 8191); end
        default: begin
          idle_pct = 24; stall_pct = 24;
          set_screen($urandom_range(8191), $urandom_range(8191));
        end
      endcase
      while (sent < 25 + (phase + 1) * RANDOM_WORDS / 4) random_line();
    end

    // drain and settle
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (errors == 0 && pending == 0)
      $display("gradient_line_rasterizer_tb: done, clean");
    else
      $display("gradient_line_rasterizer_tb: done, errors");
    $finish;
  end

endmodule
